@@ hdl/random_probe_hash_table_macros.svh @@
// Assertion macros for the random probe hash table.
// RPHT_ASSERT_IMP checks a same-cycle implication, RPHT_ASSERT_NXT one
// that spans into the next cycle. Both are off while reset is low.
`ifndef RANDOM_PROBE_HASH_TABLE_MACROS_SVH
`define RANDOM_PROBE_HASH_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define RPHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpht: check failed");
`define RPHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpht: check failed");
`else
`define RPHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RPHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/rpht_pkg.sv @@
`default_nettype none

package rpht_pkg;

    // table geometry
    localparam int DEF_BUCKETS = 8;
    localparam int NUM_OFFSETS = 7;
    localparam int OFF_W       = 3;
    localparam int OFF_IDX_W   = 3;
    localparam int KEY_W       = 31;
    localparam int DIGIT_W     = 4;

    // result field widths
    localparam int STATUS_W = 2;
    localparam int BUCKET_W = 3;
    localparam int PROBES_W = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISS     = 2'd3
    } t_status;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        t_status             status;
        logic [BUCKET_W-1:0] bucket;
        logic [PROBES_W-1:0] probes;
    } t_out_word;

endpackage

`default_nettype wire

@@ hdl/random_probe_hash_table.sv @@
// Open-addressed hash table of BUCKETS key slots with random probing.
// Input channel (i_in_valid / o_in_stall) takes one request word: insert
// or search of a 31-bit key. Output channel (o_out_valid / i_out_stall)
// returns one result word per request: status, bucket and probe count.
// Probe offsets 1..7 are written on the config port (i_cfg_we, i_cfg_idx,
// i_cfg_data); index 7 is ignored. The user must write them only while the
// table is idle; the block does not enforce this. One request at a time.
// Probes issue one per cycle through the key memory read port; the
// registered read data is compared in the next stage and the result word
// is loaded in S_FINISH. When BUCKETS is not a power of two the home
// bucket is first reduced four key bits per cycle in S_HOME.
// The result stays in the output register while i_out_stall is high; a
// new request may be taken meanwhile but cannot finish until the
// register is free. Reset empties the table (all slots invalid), resets
// offsets to 1..7 and drops any pending result.
`default_nettype none
`include "random_probe_hash_table_macros.svh"

module random_probe_hash_table #(
    parameter int BUCKETS = rpht_pkg::DEF_BUCKETS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire rpht_pkg::t_in_word            i_in_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output rpht_pkg::t_out_word                o_out_word,
    input  wire logic                          i_cfg_we,
    input  wire logic [rpht_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rpht_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rpht_pkg::*;

    localparam int  SLOT_W     = $clog2(BUCKETS);
    localparam int  VAL_W      = $clog2(2 * BUCKETS + 7);
    localparam bit  IS_POW2    = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam int  KEY_DIGITS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
    localparam int  SHIFT_W    = KEY_DIGITS * DIGIT_W;
    localparam int  DCNT_W     = $clog2(KEY_DIGITS);
    localparam int  BKT_EXT_W  = (SLOT_W > BUCKET_W) ? SLOT_W : BUCKET_W;
    localparam int  PRB_EXT_W  = (SLOT_W + 1 > PROBES_W) ? SLOT_W + 1 : PROBES_W;
    localparam logic [SLOT_W-1:0]    LAST_PROBE = SLOT_W'(BUCKETS - 1);
    localparam logic [OFF_IDX_W-1:0] LAST_OFF   = OFF_IDX_W'(NUM_OFFSETS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HOME,
        S_PROBE,
        S_FINISH
    } t_state;

    t_state               r_state;
    logic [OFF_W-1:0]     r_offset [NUM_OFFSETS];
    logic                 r_search;
    logic [KEY_W-1:0]     r_key;
    logic [SHIFT_W-1:0]   r_shift;
    logic [DCNT_W-1:0]    r_dig_cnt;
    logic [SLOT_W-1:0]    r_home;
    logic                 r_iss_active;
    logic [SLOT_W-1:0]    r_iss_idx;
    logic [OFF_IDX_W-1:0] r_off_idx;
    logic                 r_cmp_vld;
    logic [SLOT_W-1:0]    r_cmp_idx;
    logic [SLOT_W-1:0]    r_cmp_slot;
    t_out_word            r_res;
    logic                 r_out_valid;
    t_out_word            r_out_word;

    logic                 in_accept;
    logic                 unit_shift;
    logic [VAL_W-1:0]     unit_base;
    logic [DIGIT_W-1:0]   unit_digits;
    logic [SLOT_W-1:0]    unit_rem;
    logic [SLOT_W-1:0]    iss_slot;
    logic                 rd_en;
    logic [KEY_W-1:0]     st_rd_key;
    logic                 st_rd_valid;
    logic                 wr_en;
    logic                 hit_empty;
    logic                 hit_match;
    logic                 cmp_done;
    logic [SLOT_W:0]      probe_cnt;
    logic [BKT_EXT_W-1:0] bkt_ext;
    logic [PRB_EXT_W-1:0] prb_ext;
    t_out_word            cmp_res;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // shared unit: key reduction in S_HOME, home + offset otherwise
    always_comb begin
        if (r_state == S_HOME) begin
            unit_shift  = 1'b1;
            unit_base   = VAL_W'(r_home);
            unit_digits = r_shift[SHIFT_W-1 -: DIGIT_W];
        end else begin
            unit_shift  = 1'b0;
            unit_base   = VAL_W'(r_home) + VAL_W'(r_offset[r_off_idx]);
            unit_digits = '0;
        end
    end

    rpht_mod_unit #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .i_shift  (unit_shift),
        .i_base   (unit_base),
        .i_digits (unit_digits),
        .o_rem    (unit_rem)
    );

    // probe issue: home slot first, then offset slots
    assign iss_slot = (r_iss_idx == '0) ? r_home : unit_rem;
    assign rd_en    = (r_state == S_PROBE) && r_iss_active;

    // compare stage, in the cycle after issue
    assign hit_empty = !st_rd_valid;
    assign hit_match = r_search && st_rd_valid && (st_rd_key == r_key);
    assign cmp_done  = r_cmp_vld && (hit_empty || hit_match || (r_cmp_idx == LAST_PROBE));
    assign wr_en     = r_cmp_vld && hit_empty && !r_search;

    rpht_slot_store #(
        .BUCKETS (BUCKETS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (iss_slot),
        .o_rd_key   (st_rd_key),
        .o_rd_valid (st_rd_valid),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_cmp_slot),
        .i_wr_key   (r_key)
    );

    // result word of the terminating probe
    always_comb begin
        probe_cnt = {1'b0, r_cmp_idx} + (SLOT_W + 1)'(1);
        prb_ext   = PRB_EXT_W'(probe_cnt);
        bkt_ext   = BKT_EXT_W'(r_cmp_slot);
        cmp_res.probes = prb_ext[PROBES_W-1:0];
        cmp_res.bucket = '0;
        if (hit_empty) begin
            if (r_search) begin
                cmp_res.status = ST_MISS;
            end else begin
                cmp_res.status = ST_INSERTED;
                cmp_res.bucket = bkt_ext[BUCKET_W-1:0];
            end
        end else if (hit_match) begin
            cmp_res.status = ST_FOUND;
            cmp_res.bucket = bkt_ext[BUCKET_W-1:0];
        end else if (r_search) begin
            cmp_res.status = ST_MISS;
        end else begin
            cmp_res.status = ST_FULL;
        end
    end

    // offset registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_OFFSETS; i++) begin
                r_offset[i] <= OFF_W'(i + 1);
            end
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_OFFSETS))) begin
            r_offset[i_cfg_idx] <= i_cfg_data;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_search <= (i_in_word.req_type == REQ_SEARCH);
            r_key    <= i_in_word.key;
            r_shift  <= SHIFT_W'(i_in_word.key);
        end else if (r_state == S_HOME) begin
            r_shift  <= r_shift << DIGIT_W;
        end
    end

    // compare stage payload
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_cmp_idx  <= r_iss_idx;
            r_cmp_slot <= iss_slot;
        end
        if (cmp_done) begin
            r_res <= cmp_res;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dig_cnt    <= '0;
            r_home       <= '0;
            r_iss_active <= 1'b0;
            r_iss_idx    <= '0;
            r_off_idx    <= '0;
            r_cmp_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // a word taken while a new one loads is handled in S_FINISH
            if (r_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_iss_idx <= '0;
                        r_off_idx <= '0;
                        r_cmp_vld <= 1'b0;
                        if (IS_POW2) begin
                            r_home       <= i_in_word.key[SLOT_W-1:0];
                            r_iss_active <= 1'b1;
                            r_state      <= S_PROBE;
                        end else begin
                            r_home    <= '0;
                            r_dig_cnt <= '0;
                            r_state   <= S_HOME;
                        end
                    end
                end
                S_HOME: begin
                    r_home    <= unit_rem;
                    r_dig_cnt <= r_dig_cnt + DCNT_W'(1);
                    if (r_dig_cnt == DCNT_W'(KEY_DIGITS - 1)) begin
                        r_iss_active <= 1'b1;
                        r_state      <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (cmp_done) begin
                        r_iss_active <= 1'b0;
                        r_cmp_vld    <= 1'b0;
                        r_state      <= S_FINISH;
                    end else begin
                        r_cmp_vld <= r_iss_active;
                        if (r_iss_active) begin
                            if (r_iss_idx == LAST_PROBE) begin
                                r_iss_active <= 1'b0;
                            end else begin
                                r_iss_idx <= r_iss_idx + SLOT_W'(1);
                            end
                            if (r_iss_idx != '0) begin
                                r_off_idx <= (r_off_idx == LAST_OFF) ? '0
                                           : r_off_idx + OFF_IDX_W'(1);
                            end
                        end
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FINISH) && (!r_out_valid || !i_out_stall)) begin
            r_out_word <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // checks
    `RPHT_ASSERT_IMP(a_cmp_in_probe, i_clk, i_rst_n, r_cmp_vld, r_state == S_PROBE)
    `RPHT_ASSERT_IMP(a_finish_quiet, i_clk, i_rst_n, r_state == S_FINISH, !r_iss_active && !r_cmp_vld)
    `RPHT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_accept, r_state != S_IDLE)
    `RPHT_ASSERT_IMP(a_out_from_finish, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_FINISH))

endmodule

`default_nettype wire

@@ hdl/rpht_mod_unit.sv @@
`default_nettype none

// Shared remainder unit: four conditional subtract steps per cycle.
// Shift mode folds four key bits into a running remainder; add mode
// reduces home bucket plus offset back into the table range.
module rpht_mod_unit #(
    parameter int  BUCKETS = rpht_pkg::DEF_BUCKETS,
    localparam int SLOT_W  = $clog2(BUCKETS),
    localparam int VAL_W   = $clog2(2 * BUCKETS + 7)
) (
    input  wire logic                        i_shift,
    input  wire logic [VAL_W-1:0]            i_base,
    input  wire logic [rpht_pkg::DIGIT_W-1:0] i_digits,
    output logic      [SLOT_W-1:0]           o_rem
);
    import rpht_pkg::*;

    logic [VAL_W-1:0] v;

    always_comb begin
        v = i_base;
        for (int s = 0; s < DIGIT_W; s++) begin
            if (i_shift) begin
                v = {v[VAL_W-2:0], i_digits[DIGIT_W-1-s]};
            end
            if (v >= VAL_W'(BUCKETS)) begin
                v = v - VAL_W'(BUCKETS);
            end
        end
        o_rem = v[SLOT_W-1:0];
    end

endmodule

`default_nettype wire

@@ hdl/rpht_slot_store.sv @@
`default_nettype none

// Key memory with one read and one write port, registered read data.
// Valid bits live in flops and clear at reset.
module rpht_slot_store #(
    parameter int  BUCKETS = rpht_pkg::DEF_BUCKETS,
    localparam int SLOT_W  = $clog2(BUCKETS)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_rd_en,
    input  wire logic [SLOT_W-1:0]         i_rd_addr,
    output logic      [rpht_pkg::KEY_W-1:0] o_rd_key,
    output logic                           o_rd_valid,
    input  wire logic                      i_wr_en,
    input  wire logic [SLOT_W-1:0]         i_wr_addr,
    input  wire logic [rpht_pkg::KEY_W-1:0] i_wr_key
);
    import rpht_pkg::*;

    logic [KEY_W-1:0]   r_mem [BUCKETS];
    logic [BUCKETS-1:0] r_valid;
    logic [KEY_W-1:0]   r_rd_key;
    logic               r_rd_valid;

    // key array, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_key;
        end
        if (i_rd_en) begin
            r_rd_key <= r_mem[i_rd_addr];
        end
    end

    // occupancy flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_valid = r_rd_valid;

endmodule

`default_nettype wire
